>>> design/sjn_pkg.sv
package sjn_pkg;

    localparam int ID_BITS     = 16;
    localparam int LENGTH_BITS = 16;

    typedef logic [ID_BITS-1:0]     t_id;
    typedef logic [LENGTH_BITS-1:0] t_len;

    typedef enum logic [0:0] {
        KIND_ARRIVE = 1'b0,
        KIND_TICK   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_id   id;
        t_len  len;
    } t_cmd;

    typedef struct packed {
        logic ran;
        t_id  id;
        logic dropped;
    } t_result;

endpackage

>>> design/sjn_if.sv
interface sjn_job_if;
    import sjn_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    t_id  task_id;
    t_len task_length;

    modport source (output valid, output kind, output task_id, output task_length,
                    input ready);
    modport sink   (input valid, input kind, input task_id, input task_length,
                    output ready);
endinterface

interface sjn_result_if;
    import sjn_pkg::*;

    logic valid;
    logic ready;
    logic ran_task;
    t_id  running_id;
    logic dropped;

    modport source (output valid, output ran_task, output running_id, output dropped,
                    input ready);
    modport sink   (input valid, input ran_task, input running_id, input dropped,
                    output ready);
endinterface

>>> design/sjn_front.sv
module sjn_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sjn_job_if.sink          i_job,
    output logic             o_cmd_valid,
    output sjn_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_pop
);
    import sjn_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    t_cmd       n_cmd;
    logic       w_push;

    always_comb begin
        n_cmd.kind = t_kind'(i_job.kind);
        n_cmd.id   = i_job.task_id;
        n_cmd.len  = (i_job.task_length == '0) ? t_len'(1) : i_job.task_length;
    end

    assign i_job.ready = (r_fill != 2'd2);
    assign w_push      = i_job.valid && i_job.ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= n_cmd;
        end
    end

endmodule

>>> design/sjn_back.sv
module sjn_back #(
    parameter int WAIT_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  sjn_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    sjn_result_if.source     o_result
);
    import sjn_pkg::*;

    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

    // The waiting store is kept sorted by length, equal lengths in arrival order.
    t_id              r_ids  [WAIT_DEPTH];
    t_len             r_lens [WAIT_DEPTH];
    t_id              n_ids  [WAIT_DEPTH];
    t_len             n_lens [WAIT_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_id              r_cur;
    t_id              n_cur;
    t_len             r_rem;
    t_len             n_rem;
    logic             r_out_valid;
    t_result          r_out;
    t_result          n_out;

    logic                  w_fire;
    logic                  w_insert;
    logic                  w_pop;
    logic [WAIT_DEPTH-1:0] w_le;
    logic [WAIT_DEPTH-1:0] w_prev_le;

    assign w_fire    = i_cmd_valid && (!r_out_valid || o_result.ready);
    assign o_cmd_pop = w_fire;

    for (genvar k = 0; k < WAIT_DEPTH; k++) begin : g_cell
        assign w_le[k] = (r_count > CNT_W'(k)) && (r_lens[k] <= i_cmd.len);

        if (k == 0) begin : g_head
            assign w_prev_le[k] = 1'b1;
        end else begin : g_body
            assign w_prev_le[k] = w_le[k-1];
        end

        always_comb begin
            n_ids[k]  = r_ids[k];
            n_lens[k] = r_lens[k];
            if (w_pop) begin
                if (k < WAIT_DEPTH - 1) begin
                    n_ids[k]  = r_ids[(k < WAIT_DEPTH - 1) ? k + 1 : k];
                    n_lens[k] = r_lens[(k < WAIT_DEPTH - 1) ? k + 1 : k];
                end
            end else if (w_insert && !w_le[k]) begin
                if (w_prev_le[k]) begin
                    n_ids[k]  = i_cmd.id;
                    n_lens[k] = i_cmd.len;
                end else begin
                    n_ids[k]  = r_ids[(k > 0) ? k - 1 : k];
                    n_lens[k] = r_lens[(k > 0) ? k - 1 : k];
                end
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_cur    = r_cur;
        n_rem    = r_rem;
        n_out    = '0;
        w_insert = 1'b0;
        w_pop    = 1'b0;
        if (w_fire) begin
            unique case (i_cmd.kind)
                KIND_ARRIVE: begin
                    if (r_count == '0 && r_rem == '0) begin
                        n_cur = i_cmd.id;
                        n_rem = i_cmd.len;
                    end else if (r_count != CNT_W'(WAIT_DEPTH)) begin
                        w_insert = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end else begin
                        n_out.dropped = 1'b1;
                    end
                end
                KIND_TICK: begin
                    if (r_rem == '0 && r_count != '0) begin
                        w_pop     = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                        n_cur     = r_ids[0];
                        n_rem     = r_lens[0] - t_len'(1);
                        n_out.ran = 1'b1;
                        n_out.id  = r_ids[0];
                    end else if (r_rem != '0) begin
                        n_rem     = r_rem - t_len'(1);
                        n_out.ran = 1'b1;
                        n_out.id  = r_cur;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_cur   <= n_cur;
            r_rem   <= n_rem;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids  <= n_ids;
        r_lens <= n_lens;
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.ran_task   = r_out.ran;
    assign o_result.running_id = r_out.id;
    assign o_result.dropped    = r_out.dropped;

endmodule

>>> design/shortest_job_next_scheduler.sv
// Each beat gives exactly one result beat; the back end registers it.
// One beat is taken every cycle as long as results are taken; a two-entry queue
// sits between the classifying front end and the scheduling back end.
// Arrivals go to sorted place (dropped when full); a tick pops the head when idle.
// Synchronous reset clears the queue, the waiting count and the running task at once;
// the waiting entries themselves are not cleared and need no clearing pass.
module shortest_job_next_scheduler #(
    parameter int WAIT_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sjn_job_if.sink       i_job,
    sjn_result_if.source  o_result
);
    import sjn_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    sjn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (i_job),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    sjn_back #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result)
    );

endmodule

>>> design/sjn_checker.sv
module sjn_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic          i_ran_task,
    input sjn_pkg::t_id  i_running_id,
    input logic          i_dropped
);
    import sjn_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ran_task)
            && $stable(i_running_id) && $stable(i_dropped))
        else $error("Result beat changed while stalled.");

    a_ran_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_ran_task && i_dropped))
        else $error("A result beat both ran a task and dropped one.");

    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ran_task |-> i_running_id == '0)
        else $error("Running id is nonzero on a beat that ran no task.");

endmodule

bind shortest_job_next_scheduler sjn_checker u_sjn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_ran_task   (o_result.ran_task),
    .i_running_id (o_result.running_id),
    .i_dropped    (o_result.dropped)
);

>>> dv/tb_shortest_job_next_scheduler.sv
`timescale 1ns / 1ps

module tb_shortest_job_next_scheduler;
    import sjn_pkg::*;

    localparam int WAIT_DEPTH = 16;

    logic i_clk;
    logic i_rst_n;

    sjn_job_if    job_bus ();
    sjn_result_if result_bus ();

    shortest_job_next_scheduler #(
        .WAIT_DEPTH(WAIT_DEPTH)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job_bus),
        .o_result (result_bus)
    );

    t_id     sched_wait_id [WAIT_DEPTH];
    t_len    sched_wait_len[WAIT_DEPTH];
    int      sched_waiting;
    t_id     sched_run_id;
    t_len    sched_left;

    t_result expected_q[$];
    int      fault_count;
    int      send_gap_max;
    int      sink_gap_max;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int draw_gap(input int max_gap);
        return (max_gap == 0) ? 0 : int'($urandom_range(max_gap, 0));
    endfunction

    function automatic t_result schedule_step(input t_kind kind, input t_id id, input t_len len);
        t_result r;
        int      pick;
        r = '0;
        if (kind == KIND_ARRIVE) begin
            if (len == 0) begin
                len = t_len'(1);
            end
            if (sched_waiting == 0 && sched_left == 0) begin
                sched_run_id = id;
                sched_left   = len;
            end else if (sched_waiting < WAIT_DEPTH) begin
                sched_wait_id[sched_waiting]  = id;
                sched_wait_len[sched_waiting] = len;
                sched_waiting++;
            end else begin
                r.dropped = 1'b1;
            end
        end else begin
            if (sched_left == 0 && sched_waiting > 0) begin
                pick = 0;
                for (int j = 1; j < sched_waiting; j++) begin
                    if (sched_wait_len[j] < sched_wait_len[pick]) begin
                        pick = j;
                    end
                end
                sched_run_id = sched_wait_id[pick];
                sched_left   = sched_wait_len[pick];
                for (int j = pick; j + 1 < sched_waiting; j++) begin
                    sched_wait_id[j]  = sched_wait_id[j + 1];
                    sched_wait_len[j] = sched_wait_len[j + 1];
                end
                sched_waiting--;
            end
            if (sched_left > 0) begin
                r.ran = 1'b1;
                r.id  = sched_run_id;
                sched_left--;
            end
        end
        return r;
    endfunction

    task automatic send_job(input t_kind kind, input t_id id, input t_len len);
        int gap;
        gap = draw_gap(send_gap_max);
        if (gap > 0) begin
            job_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        job_bus.valid       <= 1'b1;
        job_bus.kind        <= kind;
        job_bus.task_id     <= id;
        job_bus.task_length <= len;
        do @(posedge i_clk); while (!job_bus.ready);
        expected_q.push_back(schedule_step(kind, id, len));
    endtask

    task automatic wait_drained();
        job_bus.valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    // Result side: random back-pressure and in-order comparison of each beat.
    initial begin
        int      stall_left;
        t_result want;
        stall_left        = 0;
        fault_count       = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_bus.valid && result_bus.ready) begin
                if (expected_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected result beat: ran=%0d id=%h dropped=%0d",
                                 result_bus.ran_task, result_bus.running_id,
                                 result_bus.dropped);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (result_bus.ran_task !== want.ran || result_bus.running_id !== want.id
                        || result_bus.dropped !== want.dropped) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display({"mismatch: expected ran=%0d id=%h dropped=%0d, ",
                                      "got ran=%0d id=%h dropped=%0d"},
                                     want.ran, want.id, want.dropped, result_bus.ran_task,
                                     result_bus.running_id, result_bus.dropped);
                        end
                    end
                end
                stall_left = draw_gap(sink_gap_max);
            end
            if (stall_left > 0) begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic test_idle_tick();
        send_job(KIND_TICK, 16'h0000, 16'h0000);
        send_job(KIND_TICK, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_zero_length();
        send_job(KIND_ARRIVE, 16'h0000, 16'h0000);
        send_job(KIND_TICK, 16'h1234, 16'h0000);
        send_job(KIND_TICK, 16'h0000, 16'h0000);
    endtask

    task automatic test_full_store();
        t_len lens[WAIT_DEPTH] = '{16'd5, 16'd2, 16'd7, 16'd2, 16'd9, 16'd1, 16'd4, 16'd4,
                                   16'd0, 16'd8, 16'd6, 16'd3, 16'd1, 16'd12, 16'd10, 16'd11};
        send_job(KIND_ARRIVE, 16'hA5A5, 16'd3);
        for (int j = 0; j < WAIT_DEPTH; j++) begin
            send_job(KIND_ARRIVE, t_id'(16'h0100 + j), lens[j]);
        end
        send_job(KIND_ARRIVE, 16'hFFFF, 16'hFFFF);
        send_job(KIND_TICK, 16'h0000, 16'h0000);
        send_job(KIND_ARRIVE, 16'h5A5A, 16'h8000);
    endtask

    task automatic test_drain();
        while (sched_left != 0 || sched_waiting != 0) begin
            send_job(KIND_TICK, t_id'($urandom), t_len'($urandom));
        end
        send_job(KIND_TICK, t_id'($urandom), t_len'($urandom));
    endtask

    // Segments draw an arrival share of 15 to 85 percent so that the store both
    // overflows and empties; only ticks and refused arrivals get long lengths.
    task automatic test_random_traffic(input int n_items);
        int    arrive_pct;
        t_kind kind;
        t_len  len;
        for (int seg = 0; seg < n_items / 50; seg++) begin
            arrive_pct   = $urandom_range(85, 15);
            send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 6;
            sink_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 6;
            if (seg == n_items / 100) begin
                wait_drained();
            end
            for (int j = 0; j < 50; j++) begin
                kind = ($urandom_range(99, 0) < arrive_pct) ? KIND_ARRIVE : KIND_TICK;
                if (kind == KIND_TICK || sched_waiting == WAIT_DEPTH) begin
                    len = t_len'($urandom);
                end else if ($urandom_range(9, 0) == 0) begin
                    len = '0;
                end else if ($urandom_range(7, 0) == 0) begin
                    len = t_len'($urandom_range(20, 7));
                end else begin
                    len = t_len'($urandom_range(6, 1));
                end
                send_job(kind, t_id'($urandom), len);
            end
        end
    endtask

    initial begin
        for (int j = 0; j < WAIT_DEPTH; j++) begin
            sched_wait_id[j]  = '0;
            sched_wait_len[j] = '0;
        end
        sched_waiting = 0;
        sched_run_id  = '0;
        sched_left    = '0;
        send_gap_max  = 0;
        sink_gap_max  = 0;

        i_rst_n             <= 1'b0;
        job_bus.valid       <= 1'b0;
        job_bus.kind        <= KIND_ARRIVE;
        job_bus.task_id     <= '0;
        job_bus.task_length <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_tick();
        test_zero_length();
        test_full_store();
        send_gap_max = 6;
        sink_gap_max = 6;
        test_drain();
        wait_drained();
        test_random_traffic(1450);
        test_drain();
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (fault_count == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/sjn_pkg.sv
design/sjn_if.sv
design/sjn_front.sv
design/sjn_back.sv
design/shortest_job_next_scheduler.sv
design/sjn_checker.sv
dv/tb_shortest_job_next_scheduler.sv
